@@ sv/sql_host_variable_tokenizer_core_macros.svh @@
// Assertion macros shared by the checker of the host variable tokenizer.
// Depends on nothing; the including scope supplies clk and rst_n.
`ifndef SQL_HOST_VARIABLE_TOKENIZER_CORE_MACROS_SVH
`define SQL_HOST_VARIABLE_TOKENIZER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define HVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define HVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/hvt_pkg.sv @@
// Types and constants of the host variable tokenizer.
// Used by the scanner, the emitter and the top level; depends on nothing.
package hvt_pkg;

  localparam logic [31:0] HVT_MAX_STATEMENT_BYTES = 32'd65535;
  localparam logic [15:0] POS_CAP =
    (HVT_MAX_STATEMENT_BYTES < 32'd65535) ? HVT_MAX_STATEMENT_BYTES[15:0] : 16'hFFFF;

  localparam logic [7:0] CH_QUOTE      = 8'h27;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  localparam int unsigned SLOTS = 3;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_HOST   = 2'd1,
    MODE_LIT    = 2'd2,
    MODE_LITQ   = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [15:0] token_start;
    logic [15:0] token_end;
    logic        is_host_var;
    logic [15:0] token_number;
    logic        statement_done;
    logic        too_long;
  } token_t;

  typedef struct packed {
    logic        load;
    logic [1:0]  count;
    token_t [SLOTS-1:0] slot;
  } bundle_t;

  function automatic logic ident_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDERSCORE);
  endfunction

endpackage

@@ sv/hvt_if.sv @@
// Valid/ready channel interfaces for statement bytes and token requests.
// Depends on nothing.
interface hvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;

  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface hvt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] token_start;
  logic [15:0] token_end;
  logic        is_host_var;
  logic [15:0] token_number;
  logic        statement_done;
  logic        too_long;
  logic        last_of_run;

  modport source (output valid, output token_start, output token_end,
                  output is_host_var, output token_number, output statement_done,
                  output too_long, output last_of_run, input ready);
  modport sink   (input valid, input token_start, input token_end,
                  input is_host_var, input token_number, input statement_done,
                  input too_long, input last_of_run, output ready);
endinterface

@@ sv/hvt_scan.sv @@
// Per-byte scanner: mode machine, position counters and token bundle build.
// Depends on hvt_pkg.
module hvt_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [7:0]      char_byte,
  input  logic            last_byte,
  output hvt_pkg::bundle_t bundle
);
  import hvt_pkg::*;

  scan_mode_t  mode_r, mode_nxt, mode_mid;
  logic [15:0] byte_position_r, byte_position_nxt;
  logic [15:0] plain_begin_r, plain_begin_nxt;
  logic [15:0] host_begin_r, host_begin_nxt;
  logic [15:0] tokens_emitted_r, tokens_emitted_nxt;
  logic        overflow_seen_r, overflow_seen_nxt;

  logic        fire;
  logic        at_cap;
  logic [15:0] cur;
  logic [15:0] nxt;
  logic        is_colon;
  logic        is_quote;
  logic        host_close;
  logic        as_normal;
  logic        plain_cut;
  logic [15:0] pb_mid;
  logic [15:0] hb_mid;
  logic        tail_host;

  token_t      cand [4];
  logic [3:0]  cand_v;
  logic [1:0]  count;
  logic [16:0] te_sum;

  assign fire     = in_valid && in_ready;
  assign at_cap   = byte_position_r >= POS_CAP;
  assign cur      = at_cap ? POS_CAP : byte_position_r;
  assign nxt      = (cur == POS_CAP) ? POS_CAP : cur + 16'd1;
  assign is_colon = char_byte == CH_COLON;
  assign is_quote = char_byte == CH_QUOTE;

  always_comb begin
    host_close = 1'b0;
    as_normal  = 1'b0;
    mode_mid   = mode_r;
    case (mode_r)
      MODE_HOST: begin
        if (!(ident_char(char_byte) || is_colon)) begin
          host_close = 1'b1;
          as_normal  = 1'b1;
          mode_mid   = MODE_NORMAL;
        end
      end
      MODE_LIT: begin
        if (is_quote) mode_mid = MODE_LITQ;
      end
      MODE_LITQ: begin
        if (is_quote) begin
          mode_mid = MODE_LIT;
        end else begin
          mode_mid  = MODE_NORMAL;
          as_normal = 1'b1;
        end
      end
      default: as_normal = 1'b1;
    endcase
    if (as_normal && is_colon) begin
      mode_mid = MODE_HOST;
    end else if (as_normal && is_quote) begin
      mode_mid = MODE_LIT;
    end
    mode_nxt = last_byte ? MODE_NORMAL : mode_mid;
  end

  always_comb begin
    pb_mid    = host_close ? cur : plain_begin_r;
    plain_cut = as_normal && is_colon && (pb_mid < cur);
    hb_mid    = (as_normal && is_colon) ? cur : host_begin_r;
    tail_host = last_byte && (mode_mid == MODE_HOST);

    cand_v = {last_byte, tail_host, plain_cut, host_close};

    cand[0] = '{token_start: host_begin_r, token_end: cur, is_host_var: 1'b1,
                token_number: 16'd0, statement_done: 1'b0, too_long: overflow_seen_nxt};
    cand[1] = '{token_start: pb_mid, token_end: cur, is_host_var: 1'b0,
                token_number: 16'd0, statement_done: 1'b0, too_long: overflow_seen_nxt};
    cand[2] = '{token_start: hb_mid, token_end: nxt, is_host_var: 1'b1,
                token_number: 16'd0, statement_done: 1'b0, too_long: overflow_seen_nxt};
    cand[3] = '{token_start: tail_host ? nxt : pb_mid, token_end: nxt, is_host_var: 1'b0,
                token_number: 16'd0, statement_done: 1'b1, too_long: overflow_seen_nxt};
  end

  always_comb begin
    bundle.load  = fire;
    bundle.slot  = '0;
    count        = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (cand_v[k]) begin
        te_sum = {1'b0, tokens_emitted_r} + {15'd0, count};
        bundle.slot[count] = cand[k];
        bundle.slot[count].token_number = te_sum[16] ? 16'hFFFF : te_sum[15:0];
        count = count + 2'd1;
      end
    end
    te_sum = {1'b0, tokens_emitted_r} + {15'd0, count};
    bundle.count = count;
  end

  always_comb begin
    overflow_seen_nxt  = overflow_seen_r || at_cap;
    byte_position_nxt  = nxt;
    plain_begin_nxt    = pb_mid;
    host_begin_nxt     = hb_mid;
    tokens_emitted_nxt = te_sum[16] ? 16'hFFFF : te_sum[15:0];
    if (last_byte) begin
      byte_position_nxt  = 16'd0;
      plain_begin_nxt    = 16'd0;
      host_begin_nxt     = 16'd0;
      tokens_emitted_nxt = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= MODE_NORMAL;
      byte_position_r  <= 16'd0;
      plain_begin_r    <= 16'd0;
      host_begin_r     <= 16'd0;
      tokens_emitted_r <= 16'd0;
      overflow_seen_r  <= 1'b0;
    end else if (fire) begin
      mode_r           <= mode_nxt;
      byte_position_r  <= byte_position_nxt;
      plain_begin_r    <= plain_begin_nxt;
      host_begin_r     <= host_begin_nxt;
      tokens_emitted_r <= tokens_emitted_nxt;
      overflow_seen_r  <= last_byte ? 1'b0 : overflow_seen_nxt;
    end
  end

endmodule

@@ sv/hvt_emit.sv @@
// Result register: holds the token bundle of one byte and drains it one
// request per cycle while out_ready is high. Depends on hvt_pkg.
module hvt_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  hvt_pkg::bundle_t bundle,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output hvt_pkg::token_t  out_token,
  output logic             out_last_of_run
);
  import hvt_pkg::*;

  token_t [SLOTS-1:0] slot_r;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [1:0]         sel;
  logic [2:0]         idx_inc;

  assign idx_inc         = {1'b0, idx_r} + 3'd1;
  assign out_valid       = idx_r < cnt_r;
  assign out_last_of_run = idx_inc == {1'b0, cnt_r};
  assign in_ready        = !out_valid || (out_last_of_run && out_ready);
  assign sel             = (idx_r > 2'd2) ? 2'd2 : idx_r;
  assign out_token       = slot_r[sel];

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (bundle.load) begin
      cnt_nxt = bundle.count;
      idx_nxt = 2'd0;
    end else if (out_valid && out_ready) begin
      idx_nxt = idx_inc[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (bundle.load) slot_r <= bundle.slot;
  end

endmodule

@@ sv/sql_host_variable_tokenizer_core.sv @@
// Channel   Dir  Handshake        Payload
// in_ch     in   valid/ready      char_byte[7:0], last_byte
// out_ch    out  valid/ready      token_start, token_end, is_host_var, token_number,
//                                 statement_done, too_long, last_of_run
// One byte a cycle while the output is ready; a byte that yields several tokens holds
// the input while the result register drains, one token request per cycle.
// The input is taken while the last token of the previous byte is taken.
// Reset: synchronous, active low; clears the scan state and empties the result register.
// Top level of the host variable tokenizer; depends on hvt_pkg, hvt_if, hvt_scan, hvt_emit.
module sql_host_variable_tokenizer_core (
  input logic       clk,
  input logic       rst_n,
  hvt_in_if.sink    in_ch,
  hvt_out_if.source out_ch
);
  import hvt_pkg::*;

  bundle_t bundle;
  token_t  token;
  logic    ready;
  logic    last_of_run;
  logic    valid;

  hvt_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (ready),
    .char_byte (in_ch.char_byte),
    .last_byte (in_ch.last_byte),
    .bundle    (bundle)
  );

  hvt_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .bundle          (bundle),
    .in_ready        (ready),
    .out_valid       (valid),
    .out_ready       (out_ch.ready),
    .out_token       (token),
    .out_last_of_run (last_of_run)
  );

  assign in_ch.ready           = ready;
  assign out_ch.valid          = valid;
  assign out_ch.token_start    = token.token_start;
  assign out_ch.token_end      = token.token_end;
  assign out_ch.is_host_var    = token.is_host_var;
  assign out_ch.token_number   = token.token_number;
  assign out_ch.statement_done = token.statement_done;
  assign out_ch.too_long       = token.too_long;
  assign out_ch.last_of_run    = last_of_run;

endmodule

@@ sv/hvt_checker.sv @@
// Port-level checks of the host variable tokenizer, bound to the top level.
// Depends on sql_host_variable_tokenizer_core_macros.svh.
`include "sql_host_variable_tokenizer_core_macros.svh"

module hvt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_token_start,
  input logic [15:0] out_token_end,
  input logic        out_statement_done,
  input logic        out_last_of_run
);

  `HVT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "request dropped while stalled")
  `HVT_ASSERT_NOW(a_done_last, out_valid && out_statement_done, out_last_of_run, "final token not last of run")
  `HVT_ASSERT_NOW(a_span, out_valid, out_token_start <= out_token_end, "token start past end")
  `HVT_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !out_last_of_run, out_valid, "run broken")
  `HVT_ASSERT_NOW(a_in_hold, out_valid && !(out_last_of_run && out_ready), !in_ready, "input taken with run pending")

endmodule

bind sql_host_variable_tokenizer_core hvt_checker u_hvt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_token_start    (out_ch.token_start),
  .out_token_end      (out_ch.token_end),
  .out_statement_done (out_ch.statement_done),
  .out_last_of_run    (out_ch.last_of_run)
);
